FILE: rtl/tensor_chunk_layout_planner_core_assert.svh
// Assertion macros used by the planner datapath RTL.
`ifndef TENSOR_CHUNK_LAYOUT_PLANNER_CORE_ASSERT_SVH
`define TENSOR_CHUNK_LAYOUT_PLANNER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TCLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TCLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tclp_pkg.sv
// Types, constants and the block-size table of the chunk layout planner.
package tclp_pkg;

    localparam int SIZE_W    = 48;
    localparam int DIM_W     = 32;
    localparam int TYPE_W    = 8;
    localparam int ADDR_W    = 49;
    localparam int CHUNK_W   = 16;
    localparam int ALIGN_W   = 17;
    localparam int NDIMS     = 4;
    localparam int HALF_W    = SIZE_W / 2;
    localparam int MUL_W     = HALF_W + DIM_W;
    localparam int FULL_W    = SIZE_W + DIM_W;
    localparam int ADD_W     = SIZE_W + 1;
    localparam int SHIFT_W   = 4;
    localparam int BB_W      = 9;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = SIZE_W / DIV_BITS;
    localparam int PC_W      = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_W     = 48;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_TARGET_BYTES = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_ALIGNMENT    = 1'b1;

    localparam logic [SIZE_W-1:0]  TARGET_RESET = 48'h0001_0000_0000;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET  = 17'd32;

    // Microprogram addresses
    localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] PC_DIM_LO   = 4'd1;
    localparam logic [PC_W-1:0] PC_DIM_HI   = 4'd2;
    localparam logic [PC_W-1:0] PC_DIM_SUM  = 4'd3;
    localparam logic [PC_W-1:0] PC_SCALE    = 4'd4;
    localparam logic [PC_W-1:0] PC_BB_LO    = 4'd5;
    localparam logic [PC_W-1:0] PC_BB_HI    = 4'd6;
    localparam logic [PC_W-1:0] PC_BB_SUM   = 4'd7;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd8;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd9;
    localparam logic [PC_W-1:0] PC_ALIGN    = 4'd10;
    localparam logic [PC_W-1:0] PC_ACCUM    = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd12;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_SUM,
        OP_SCALE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ALIGN,
        OP_ACCUM,
        OP_EMIT
    } op_t;

    typedef enum logic {
        MSRC_DIM,
        MSRC_BB
    } msrc_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_WAIT_REQ,
        COND_WAIT_OUT,
        COND_LOOP,
        COND_SAT
    } cond_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_LOAD,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        op_t              op;
        msrc_t            msrc;
        cond_t            cond;
        cnt_op_t          cnt_op;
        logic [CNT_W-1:0] imm;
        logic [PC_W-1:0]  target;
        logic             last;
    } uword_t;

    typedef struct packed {
        op_t   op;
        msrc_t msrc;
        logic  go;
    } dp_ctl_t;

    typedef struct packed {
        logic cnt_sat;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [TYPE_W-1:0] type_code;
        logic [DIM_W-1:0]  dim_a;
        logic [DIM_W-1:0]  dim_b;
        logic [DIM_W-1:0]  dim_c;
        logic [DIM_W-1:0]  dim_d;
        logic [SIZE_W-1:0] source_offset;
        logic [SIZE_W-1:0] part_base;
        logic              last_tensor;
    } req_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  tensor_size;
        logic [SIZE_W-1:0]  offset_in_chunk;
        logic [CHUNK_W-1:0] chunk_number;
        logic               chunk_end;
        logic [ADDR_W-1:0]  source_address;
        logic               size_overflow;
    } result_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [BB_W-1:0]    bytes;
    } blk_t;

    // Elements per block as a shift (1, 32 or 256) and bytes per block.
    function automatic blk_t blk_info(input logic [TYPE_W-1:0] code);
        blk_t b;
        case (code)
            8'd0:    b = '{4'd0, 9'd4};
            8'd1:    b = '{4'd0, 9'd2};
            8'd2:    b = '{4'd5, 9'd18};
            8'd3:    b = '{4'd5, 9'd20};
            8'd4:    b = '{4'd0, 9'd4};
            8'd5:    b = '{4'd0, 9'd4};
            8'd6:    b = '{4'd5, 9'd22};
            8'd7:    b = '{4'd5, 9'd24};
            8'd8:    b = '{4'd5, 9'd34};
            8'd9:    b = '{4'd5, 9'd36};
            8'd10:   b = '{4'd8, 9'd84};
            8'd11:   b = '{4'd8, 9'd110};
            8'd12:   b = '{4'd8, 9'd144};
            8'd13:   b = '{4'd8, 9'd176};
            8'd14:   b = '{4'd8, 9'd210};
            8'd15:   b = '{4'd8, 9'd292};
            8'd16:   b = '{4'd8, 9'd66};
            8'd17:   b = '{4'd8, 9'd74};
            8'd18:   b = '{4'd8, 9'd66};
            8'd19:   b = '{4'd8, 9'd50};
            8'd20:   b = '{4'd5, 9'd18};
            8'd21:   b = '{4'd8, 9'd82};
            8'd22:   b = '{4'd8, 9'd82};
            8'd23:   b = '{4'd8, 9'd110};
            8'd24:   b = '{4'd0, 9'd1};
            8'd25:   b = '{4'd0, 9'd2};
            8'd26:   b = '{4'd0, 9'd4};
            8'd27:   b = '{4'd0, 9'd8};
            8'd28:   b = '{4'd0, 9'd8};
            8'd29:   b = '{4'd8, 9'd56};
            8'd30:   b = '{4'd0, 9'd2};
            8'd39:   b = '{4'd5, 9'd17};
            default: b = '{4'd0, 9'd4};
        endcase
        return b;
    endfunction

    function automatic uword_t uw(input op_t op, input msrc_t msrc, input cond_t cond,
                                  input cnt_op_t cnt_op, input logic [CNT_W-1:0] imm,
                                  input logic [PC_W-1:0] target, input logic last);
        uword_t w;
        w = '{op: op, msrc: msrc, cond: cond, cnt_op: cnt_op, imm: imm,
              target: target, last: last};
        return w;
    endfunction

endpackage

FILE: rtl/tclp_seq.sv
// Microprogram ROM, step counter and loop counter of the planner.
module tclp_seq import tclp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_ctl_t  ctl
);

    logic [PC_W-1:0]  pc_reg;
    logic [PC_W-1:0]  pc_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    uword_t           word;
    logic             hold;
    logic             taken;

    function automatic uword_t rom(input logic [PC_W-1:0] addr);
        uword_t w;
        case (addr)
            PC_IDLE:     w = uw(OP_LOAD, MSRC_DIM, COND_WAIT_REQ, CNT_LOAD,
                                CNT_W'(NDIMS - 1), PC_IDLE, 1'b0);
            PC_DIM_LO:   w = uw(OP_MUL_LO, MSRC_DIM, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_DIM_HI:   w = uw(OP_MUL_HI, MSRC_DIM, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_DIM_SUM:  w = uw(OP_MUL_SUM, MSRC_DIM, COND_LOOP, CNT_DEC, '0, PC_DIM_LO, 1'b0);
            PC_SCALE:    w = uw(OP_SCALE, MSRC_BB, COND_SAT, CNT_HOLD, '0, PC_DIV_INIT, 1'b0);
            PC_BB_LO:    w = uw(OP_MUL_LO, MSRC_BB, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_BB_HI:    w = uw(OP_MUL_HI, MSRC_BB, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_BB_SUM:   w = uw(OP_MUL_SUM, MSRC_BB, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_DIV_INIT: w = uw(OP_DIV_INIT, MSRC_BB, COND_NONE, CNT_LOAD,
                                CNT_W'(DIV_STEPS - 1), PC_IDLE, 1'b0);
            PC_DIV_STEP: w = uw(OP_DIV_STEP, MSRC_BB, COND_LOOP, CNT_DEC, '0,
                                PC_DIV_STEP, 1'b0);
            PC_ALIGN:    w = uw(OP_ALIGN, MSRC_BB, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_ACCUM:    w = uw(OP_ACCUM, MSRC_BB, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b0);
            PC_EMIT:     w = uw(OP_EMIT, MSRC_BB, COND_WAIT_OUT, CNT_HOLD, '0, PC_EMIT, 1'b1);
            default:     w = uw(OP_NOP, MSRC_DIM, COND_NONE, CNT_HOLD, '0, PC_IDLE, 1'b1);
        endcase
        return w;
    endfunction

    assign word     = rom(pc_reg);
    assign in_stall = (word.op != OP_LOAD);

    always_comb
    begin
        // hold on a wait step until its request arrives or the output frees up
        hold = ((word.cond == COND_WAIT_REQ) && in_stall) ||
               ((word.cond == COND_WAIT_REQ) && !in_valid) ||
               ((word.cond == COND_WAIT_OUT) && stat.out_busy);
        case (word.cond)
            COND_LOOP: taken = (cnt_reg != '0);
            COND_SAT:  taken = stat.cnt_sat;
            default:   taken = hold;
        endcase
        if (taken)
        begin
            pc_next = word.target;
        end
        else if (word.last)
        begin
            pc_next = PC_IDLE;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
        cnt_next = cnt_reg;
        if (!hold)
        begin
            case (word.cnt_op)
                CNT_LOAD: cnt_next = word.imm;
                CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
                default:  cnt_next = cnt_reg;
            endcase
        end
        ctl.op   = word.op;
        ctl.msrc = word.msrc;
        ctl.go   = !hold;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/tclp_dp.sv
// Datapath of the planner: shared multiplier, remainder unit, chunk state, result register.
`include "tensor_chunk_layout_planner_core_assert.svh"

module tclp_dp import tclp_pkg::*;
#(
    parameter int SIZE_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_ctl_t              ctl,
    output dp_stat_t             stat,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_t              out_data
);

    localparam logic [SIZE_W-1:0] LIMIT = (SIZE_BITS >= SIZE_W) ? {SIZE_W{1'b1}} :
                                          SIZE_W'((64'd1 << SIZE_BITS) - 64'd1);

    logic [SIZE_W-1:0]  target_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [DIM_W-1:0]   dim_reg [NDIMS];
    logic [SHIFT_W-1:0] shift_reg;
    logic [BB_W-1:0]    bb_reg;
    logic               last_reg;
    logic [ADDR_W-1:0]  src_reg;
    logic [SIZE_W-1:0]  n_reg;
    logic [SIZE_W-1:0]  bytes_reg;
    logic [MUL_W-1:0]   mul_reg;
    logic [MUL_W-1:0]   part_reg;
    logic [ALIGN_W-1:0] rem_reg;
    logic [SIZE_W-1:0]  dq_reg;
    logic               sat_reg;
    logic               ovf_reg;
    logic [SIZE_W-1:0]  total_reg;
    logic [SIZE_W-1:0]  chunk_total_reg;
    logic [CHUNK_W-1:0] chunk_cnt_reg;
    result_t            out_reg;
    logic               out_valid_reg;

    blk_t               blk;
    logic [HALF_W-1:0]  mul_a;
    logic [DIM_W-1:0]   mul_b;
    logic [MUL_W-1:0]   mul_p;
    logic [FULL_W-1:0]  full;
    logic               full_big;
    logic [ALIGN_W-1:0] align_eff;
    logic [ALIGN_W-1:0] pad;
    logic [ALIGN_W-1:0] rem_step;
    logic [ADD_W-1:0]   add_sum;
    logic               add_big;
    logic               close;
    logic               emit;

    assign blk       = blk_info(in_data.type_code);
    assign mul_a     = (ctl.op == OP_MUL_LO) ? n_reg[HALF_W-1:0] : n_reg[SIZE_W-1:HALF_W];
    assign mul_b     = (ctl.msrc == MSRC_DIM) ? dim_reg[0] : DIM_W'(bb_reg);
    assign mul_p     = MUL_W'(mul_a) * MUL_W'(mul_b);
    assign full      = FULL_W'(part_reg) + (FULL_W'(mul_reg) << HALF_W);
    assign full_big  = (full > FULL_W'(LIMIT));
    assign align_eff = (align_reg == '0) ? ALIGN_W'(1) : align_reg;
    assign pad       = (rem_reg == '0) ? '0 : (align_eff - rem_reg);
    assign add_sum   = ADD_W'(n_reg) + ((ctl.op == OP_ALIGN) ? ADD_W'(pad) :
                                                            ADD_W'(chunk_total_reg));
    assign add_big   = (add_sum > ADD_W'(LIMIT));
    assign close     = last_reg || (total_reg >= target_reg);
    assign emit      = ctl.go && (ctl.op == OP_EMIT);

    // restoring remainder, a few dividend bits per step
    always_comb
    begin
        logic [ALIGN_W:0] t;
        rem_step = rem_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            t = {rem_step, dq_reg[SIZE_W-1-k]};
            if (t >= {1'b0, align_eff})
            begin
                t = t - {1'b0, align_eff};
            end
            rem_step = t[ALIGN_W-1:0];
        end
    end

    assign stat.cnt_sat  = sat_reg;
    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            align_reg  <= ALIGN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_BYTES: target_reg <= cfg_data[SIZE_W-1:0];
                REG_ALIGNMENT:    align_reg  <= cfg_data[ALIGN_W-1:0];
                default:          ;
            endcase
        end
    end

    // work registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.go)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    dim_reg[0] <= in_data.dim_a;
                    dim_reg[1] <= in_data.dim_b;
                    dim_reg[2] <= in_data.dim_c;
                    dim_reg[3] <= in_data.dim_d;
                    shift_reg  <= blk.shift;
                    bb_reg     <= blk.bytes;
                    last_reg   <= in_data.last_tensor;
                    src_reg    <= ADDR_W'(in_data.source_offset) + ADDR_W'(in_data.part_base);
                    n_reg      <= SIZE_W'(1);
                end
                OP_MUL_LO:
                begin
                    mul_reg <= mul_p;
                end
                OP_MUL_HI:
                begin
                    part_reg <= mul_reg;
                    mul_reg  <= mul_p;
                end
                OP_MUL_SUM:
                begin
                    n_reg <= full_big ? LIMIT : full[SIZE_W-1:0];
                    if (ctl.msrc == MSRC_DIM)
                    begin
                        for (int i = 0; i < NDIMS - 1; i++)
                        begin
                            dim_reg[i] <= dim_reg[i+1];
                        end
                    end
                end
                OP_SCALE:
                begin
                    n_reg <= sat_reg ? LIMIT : (n_reg >> shift_reg);
                end
                OP_DIV_INIT:
                begin
                    bytes_reg <= n_reg;
                    dq_reg    <= n_reg;
                    rem_reg   <= '0;
                end
                OP_DIV_STEP:
                begin
                    rem_reg <= rem_step;
                    dq_reg  <= dq_reg << DIV_BITS;
                end
                OP_ALIGN:
                begin
                    n_reg <= add_big ? LIMIT : add_sum[SIZE_W-1:0];
                end
                OP_ACCUM:
                begin
                    total_reg <= add_big ? LIMIT : add_sum[SIZE_W-1:0];
                end
                OP_EMIT:
                begin
                    out_reg.tensor_size     <= bytes_reg;
                    out_reg.offset_in_chunk <= chunk_total_reg;
                    out_reg.chunk_number    <= chunk_cnt_reg;
                    out_reg.chunk_end       <= close;
                    out_reg.source_address  <= src_reg;
                    out_reg.size_overflow   <= ovf_reg;
                end
                default: ;
            endcase
        end
    end

    // flags, chunk state and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            chunk_total_reg <= '0;
            chunk_cnt_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.go)
            begin
                case (ctl.op)
                    OP_LOAD:
                    begin
                        sat_reg <= 1'b0;
                        ovf_reg <= 1'b0;
                    end
                    OP_MUL_SUM:
                    begin
                        if (ctl.msrc == MSRC_DIM)
                        begin
                            sat_reg <= sat_reg | full_big;
                        end
                        else
                        begin
                            ovf_reg <= ovf_reg | full_big;
                        end
                    end
                    OP_SCALE:
                    begin
                        ovf_reg <= ovf_reg | sat_reg;
                    end
                    OP_ALIGN, OP_ACCUM:
                    begin
                        ovf_reg <= ovf_reg | add_big;
                    end
                    OP_EMIT:
                    begin
                        if (last_reg)
                        begin
                            chunk_total_reg <= '0;
                            chunk_cnt_reg   <= '0;
                        end
                        else if (close)
                        begin
                            chunk_total_reg <= '0;
                            chunk_cnt_reg   <= chunk_cnt_reg + CHUNK_W'(1);
                        end
                        else
                        begin
                            chunk_total_reg <= total_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `TCLP_ASSERT_IMP(a_total_in_range, 1'b1, chunk_total_reg <= LIMIT,
        "chunk total above size limit")
    `TCLP_ASSERT_IMP(a_rem_below_align, ctl.op == OP_ALIGN, rem_reg < align_eff,
        "remainder not below alignment")
    `TCLP_ASSERT_NXT(a_last_clears, emit && last_reg,
        chunk_cnt_reg == '0 && chunk_total_reg == '0, "last tensor did not clear chunk state")
    `TCLP_ASSERT_NXT(a_sat_result, emit && sat_reg,
        out_valid_reg && out_reg.size_overflow && out_reg.tensor_size == LIMIT,
        "saturated count not reported")

endmodule

FILE: rtl/tensor_chunk_layout_planner_core.sv
// The microprogram takes a request, then runs four dimension multiplies of three steps on the
// shared 24x32 multiplier, one byte multiply (skipped when the element count saturates),
// a 12-step remainder unit (4 bits a step), alignment, accumulation and the result emit;
// the next request is taken only once the result of the last one is registered.
// Reset is asynchronous active low: chunk total and counter clear, target is 2^32 bytes,
// alignment is 32 bytes; no clearing pass.
module tensor_chunk_layout_planner_core import tclp_pkg::*;
#(
    parameter int SIZE_BITS = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output result_t              out_data
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    tclp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    tclp_dp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the tensor chunk layout planner core.
module testbench import tclp_pkg::*;
;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam bit [63:0] SIZE_MAX_64 = {16'd0, SIZE_MAX};
    localparam int ITEMS_PER_PHASE = 275;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int CYCLE_LIMIT     = 1_500_000;

    typedef enum logic {
        ROW_TENSOR,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       wdata;
        req_t                   req;
        bit                     fixed;
        result_t                want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    req_t                 in_data;
    logic                 out_valid;
    logic                 out_stall;
    result_t              out_data;

    // Predictor state and its copy of the registers
    bit [SIZE_W-1:0]  run_total;
    bit [CHUNK_W-1:0] run_chunk;
    bit [SIZE_W-1:0]  cfg_target;
    bit [ALIGN_W-1:0] cfg_align;

    result_t     pending_layouts[$];
    result_t     seen_want;
    script_row_t script[$];
    int          mismatches;
    int          cycles;
    bit          idle_on;
    bit          stall_on;
    bit          hold_request;
    int          hold_left;
    int          burst_left;
    bit          burst_stall;

    tensor_chunk_layout_planner_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Elements per block in the upper half, bytes per block in the lower half.
    function automatic bit [31:0] block_shape(input logic [TYPE_W-1:0] code);
        case (code)
            8'd1, 8'd25, 8'd30: return {16'd1, 16'd2};
            8'd2, 8'd20:        return {16'd32, 16'd18};
            8'd3:               return {16'd32, 16'd20};
            8'd6:               return {16'd32, 16'd22};
            8'd7:               return {16'd32, 16'd24};
            8'd8:               return {16'd32, 16'd34};
            8'd9:               return {16'd32, 16'd36};
            8'd10:              return {16'd256, 16'd84};
            8'd11, 8'd23:       return {16'd256, 16'd110};
            8'd12:              return {16'd256, 16'd144};
            8'd13:              return {16'd256, 16'd176};
            8'd14:              return {16'd256, 16'd210};
            8'd15:              return {16'd256, 16'd292};
            8'd16, 8'd18:       return {16'd256, 16'd66};
            8'd17:              return {16'd256, 16'd74};
            8'd19:              return {16'd256, 16'd50};
            8'd21, 8'd22:       return {16'd256, 16'd82};
            8'd24:              return {16'd1, 16'd1};
            8'd27, 8'd28:       return {16'd1, 16'd8};
            8'd29:              return {16'd256, 16'd56};
            8'd39:              return {16'd32, 16'd17};
            default:            return {16'd1, 16'd4};
        endcase
    endfunction

    // Product clamped at SIZE_MAX; the top bit flags the clamp.
    function automatic bit [64:0] sat_mul(input bit [63:0] x, input bit [63:0] y);
        bit [127:0] p;
        p = 128'(x) * 128'(y);
        if (p > 128'(SIZE_MAX))
            return {1'b1, 16'd0, SIZE_MAX};
        return {1'b0, p[63:0]};
    endfunction

    function automatic result_t plan_tensor(input req_t r);
        bit [31:0]  dims [4];
        bit [31:0]  shape;
        bit [64:0]  m;
        bit [63:0]  n, per, bb, bytes, a, rem, aligned, offset, total;
        bit         count_sat, ovf, close;
        result_t    res;
        dims[0] = r.dim_a;
        dims[1] = r.dim_b;
        dims[2] = r.dim_c;
        dims[3] = r.dim_d;
        n = 64'd1;
        count_sat = 1'b0;
        ovf = 1'b0;
        for (int k = 0; k < NDIMS; k++)
        begin
            m = sat_mul(n, {32'd0, dims[k]});
            count_sat |= m[64];
            n = m[63:0];
        end
        shape = block_shape(r.type_code);
        per = {48'd0, shape[31:16]};
        bb = {48'd0, shape[15:0]};
        if (count_sat)
        begin
            ovf = 1'b1;
            bytes = SIZE_MAX_64;
        end
        else
        begin
            m = sat_mul(n / per, bb);
            ovf = m[64];
            bytes = m[63:0];
        end
        a = (cfg_align == 0) ? 64'd1 : {47'd0, cfg_align};
        aligned = bytes;
        rem = bytes % a;
        if (rem != 0)
        begin
            if (bytes > SIZE_MAX_64 - (a - rem))
            begin
                aligned = SIZE_MAX_64;
                ovf = 1'b1;
            end
            else
            begin
                aligned = bytes + a - rem;
            end
        end
        offset = {16'd0, run_total};
        if (offset > SIZE_MAX_64 - aligned)
        begin
            total = SIZE_MAX_64;
            ovf = 1'b1;
        end
        else
        begin
            total = offset + aligned;
        end
        close = r.last_tensor || (total >= {16'd0, cfg_target});
        res.tensor_size     = bytes[SIZE_W-1:0];
        res.offset_in_chunk = offset[SIZE_W-1:0];
        res.chunk_number    = run_chunk;
        res.chunk_end       = close;
        res.source_address  = {1'b0, r.source_offset} + {1'b0, r.part_base};
        res.size_overflow   = ovf;
        if (r.last_tensor)
        begin
            run_total = '0;
            run_chunk = '0;
        end
        else if (close)
        begin
            run_total = '0;
            run_chunk = run_chunk + CHUNK_W'(1);
        end
        else
        begin
            run_total = total[SIZE_W-1:0];
        end
        return res;
    endfunction

    function automatic req_t mk_req(input logic [TYPE_W-1:0] code, input logic [DIM_W-1:0] a,
                                    input logic [DIM_W-1:0] b, input logic [DIM_W-1:0] c,
                                    input logic [DIM_W-1:0] d, input logic [SIZE_W-1:0] src,
                                    input logic [SIZE_W-1:0] base, input logic last);
        req_t r;
        r = '{type_code: code, dim_a: a, dim_b: b, dim_c: c, dim_d: d,
              source_offset: src, part_base: base, last_tensor: last};
        return r;
    endfunction

    function automatic script_row_t req_row(input req_t r);
        script_row_t row;
        row = '{kind: ROW_TENSOR, reg_idx: '0, wdata: '0, req: r, fixed: 1'b0, want: '0};
        return row;
    endfunction

    function automatic script_row_t known_row(input req_t r, input result_t w);
        script_row_t row;
        row = '{kind: ROW_TENSOR, reg_idx: '0, wdata: '0, req: r, fixed: 1'b1, want: w};
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        script_row_t row;
        row = '{kind: ROW_WRITE, reg_idx: idx, wdata: data, req: '0, fixed: 1'b0, want: '0};
        return row;
    endfunction

    // Append one row to the stimulus table.
    function automatic void add_row(input script_row_t row);
        script.insert(script.size(), row);
    endfunction

    function automatic logic [SIZE_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[SIZE_W-1:0];
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Leading dimension is usually at most 400; the rest are mostly 1.
    function automatic logic [DIM_W-1:0] pick_dim(input bit lead);
        int k;
        k = $urandom_range(0, 99);
        if (k < 4)
            return '0;
        if (!lead && k < 55)
            return 32'd1;
        if (k < 82)
            return $urandom_range(1, lead ? 400 : 64);
        if (k < 94)
            return $urandom_range(1, 65536);
        return $urandom();
    endfunction

    function automatic req_t random_tensor();
        logic [TYPE_W-1:0] code;
        logic [SIZE_W-1:0] src, base;
        code = ($urandom_range(0, 99) < 80) ? TYPE_W'($urandom_range(0, 39)) :
                                              TYPE_W'($urandom_range(0, 255));
        src  = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 4095)) : rand48();
        base = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 4095)) : rand48();
        return mk_req(code, pick_dim(1'b1), pick_dim(1'b0), pick_dim(1'b0), pick_dim(1'b0),
                      src, base, $urandom_range(0, 49) == 0);
    endfunction

    task automatic send_tensor(input req_t r, input bit fixed, input result_t want);
        int gap;
        result_t p;
        gap = (idle_on && $urandom_range(0, 1)) ? idle_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (in_stall);
        p = plan_tensor(r);
        pending_layouts.insert(pending_layouts.size(), fixed ? want : p);
    endtask

    // Drop valid and let every outstanding request come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_layouts.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_TARGET_BYTES)
            cfg_target = data[SIZE_W-1:0];
        else if (idx == REG_ALIGNMENT)
            cfg_align = data[ALIGN_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_layouts.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                seen_want = pending_layouts.pop_front();
                check_field("tensor_size", 64'(seen_want.tensor_size),
                            64'(out_data.tensor_size));
                check_field("offset_in_chunk", 64'(seen_want.offset_in_chunk),
                            64'(out_data.offset_in_chunk));
                check_field("chunk_number", 64'(seen_want.chunk_number),
                            64'(out_data.chunk_number));
                check_field("chunk_end", 64'(seen_want.chunk_end), 64'(out_data.chunk_end));
                check_field("source_address", 64'(seen_want.source_address),
                            64'(out_data.source_address));
                check_field("size_overflow", 64'(seen_want.size_overflow),
                            64'(out_data.size_overflow));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        burst_left = 0;
        burst_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!stall_on)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_stall = ($urandom_range(0, 2) == 0);
                    burst_left = idle_len();
                end
                burst_left--;
                out_stall <= burst_stall;
            end
        end
    end

    initial
    begin
        logic [SIZE_W-1:0]  tgt;
        logic [CFG_W-1:0]   algn;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        hold_request = 1'b0;
        run_total = '0;
        run_chunk = '0;
        cfg_target = TARGET_RESET;
        cfg_align = ALIGN_RESET;

        // Reset values of the registers are exercised first.
        add_row(known_row(mk_req(8'd0, 1, 1, 1, 1, 0, 0, 1'b0),
                result_t'{48'd4, 48'd0, 16'd0, 1'b0, 49'd0, 1'b0}));
        add_row(known_row(mk_req(8'd1, 3, 1, 1, 1, SIZE_MAX, SIZE_MAX, 1'b0),
                result_t'{48'd6, 48'd32, 16'd0, 1'b0, 49'h1_FFFF_FFFF_FFFE, 1'b0}));
        // zero dimension
        add_row(known_row(mk_req(8'd10, 0, 7, 7, 7, 5, 10, 1'b0),
                result_t'{48'd0, 48'd64, 16'd0, 1'b0, 49'd15, 1'b0}));
        // element count saturates; the chunk closes at the clamped total
        add_row(known_row(mk_req(8'd0, '1, '1, '1, '1, 0, 0, 1'b0),
                result_t'{SIZE_MAX, 48'd64, 16'd0, 1'b1, 49'd0, 1'b1}));
        // saturation sticks even when a later dimension is zero
        add_row(known_row(mk_req(8'd0, '1, '1, 0, 1, 0, 0, 1'b0),
                result_t'{SIZE_MAX, 48'd0, 16'd1, 1'b1, 49'd0, 1'b1}));
        // exact maximum count, then rounding up overflows
        add_row(known_row(mk_req(8'd24, 16777215, 16777217, 1, 1, 0, 0, 1'b0),
                result_t'{SIZE_MAX, 48'd0, 16'd2, 1'b1, 49'd0, 1'b1}));
        add_row(req_row(mk_req(8'd15, '1, 32'hFFFF, 1, 1, 7, 9, 1'b0)));
        add_row(req_row(mk_req(8'd255, 10, 1, 1, 1, 1, 2, 1'b0)));
        add_row(req_row(mk_req(8'd40, 3, 5, 1, 1, 3, 4, 1'b0)));
        add_row(req_row(mk_req(8'd2, 33, 1, 1, 1, 100, 200, 1'b0)));
        add_row(req_row(mk_req(8'd39, 64, 3, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd0, 2, 1, 1, 1, 0, 0, 1'b1)));
        // last tensor returns both counters to zero
        add_row(known_row(mk_req(8'd0, 1, 1, 1, 1, 0, 0, 1'b0),
                result_t'{48'd4, 48'd0, 16'd0, 1'b0, 49'd0, 1'b0}));
        add_row(reg_row(REG_ALIGNMENT, 48'd0));
        add_row(req_row(mk_req(8'd1, 3, 1, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd24, 16777215, 16777217, 1, 1, 0, 0, 1'b0)));
        add_row(reg_row(REG_TARGET_BYTES, 48'd0));
        add_row(req_row(mk_req(8'd10, 0, 1, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd8, 100, 1, 1, 1, 0, 0, 1'b0)));
        add_row(reg_row(REG_TARGET_BYTES, SIZE_MAX));
        add_row(reg_row(REG_ALIGNMENT, 48'd65536));
        // two halves of the size range push the running total past its limit
        add_row(req_row(mk_req(8'd27, 32'h8000_0000, 32'h2000, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd27, 32'h8000_0000, 32'h2000, 1, 1, 0, 0, 1'b0)));
        add_row(reg_row(REG_TARGET_BYTES, 48'd1));
        add_row(reg_row(REG_ALIGNMENT, 48'd1));
        add_row(req_row(mk_req(8'd19, 255, 1, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd24, 1, 1, 1, 1, 0, 0, 1'b0)));
        add_row(req_row(mk_req(8'd29, 512, 2, 1, 1, 0, 0, 1'b1)));

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(script[i].reg_idx, script[i].wdata);
            end
            else
            begin
                send_tensor(script[i].req, script[i].fixed, script[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:
                begin
                    tgt = 48'd4096;
                    algn = 48'd32;
                end
                1:
                begin
                    tgt = SIZE_W'($urandom_range(1, 1 << 20));
                    algn = CFG_W'($urandom_range(1, 17'h1FFFF));
                end
                2:
                begin
                    tgt = SIZE_MAX;
                    algn = 48'd65536;
                end
                3:
                begin
                    tgt = 48'd1;
                    algn = 48'd1;
                end
                4:
                begin
                    // upper data bits are not part of the alignment register
                    tgt = 48'd0;
                    algn = rand48() << ALIGN_W;
                end
                default:
                begin
                    tgt = rand48();
                    algn = 48'd1 << $urandom_range(0, 16);
                end
            endcase
            write_reg(REG_TARGET_BYTES, tgt);
            write_reg(REG_ALIGNMENT, algn);
            idle_on = (ph != 3);
            stall_on = (ph != 3);
            if (ph == 2)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_tensor(random_tensor(), 1'b0, '0);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_layouts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
